// ----- hw/rtl/mlfq_pkg.sv -----
package mlfq_pkg;

    localparam int ACTION_W = 3;
    localparam int LEVEL_W  = 2;
    localparam int QUANT_W  = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SELECT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DEMOTE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_BOOST  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LVL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_Q0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Q1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q2 = 2'd2;

    localparam logic [QUANT_W-1:0] Q0_RESET = 16'd8;
    localparam logic [QUANT_W-1:0] Q1_RESET = 16'd16;
    localparam logic [QUANT_W-1:0] Q2_RESET = 16'd32;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [5:0]          task_id;
        logic [LEVEL_W-1:0]  task_level;
        logic [QUANT_W-1:0]  quantum_used;
        logic                task_terminated;
    } req_t;

    typedef struct packed {
        logic [5:0]          chosen_id;
        logic                chosen_valid;
        logic                quantum_exhausted;
        logic [LEVEL_W-1:0]  new_level;
        logic                any_ready;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic decode;
        logic exec;
        logic boost_init;
        logic boost_read;
        logic boost_write;
        logic boost_end;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_boost;
        logic boost_ok;
        logic boost_done;
        logic read_wait;
    } sts_t;

endpackage

// ----- hw/rtl/mlfq_ctrl.sv -----
module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic out_busy,
    input  sts_t sts,
    output logic in_ready,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_BREAD  = 3'd3;
    localparam logic [2:0] S_BWRITE = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load_req = in_fire;
                if (in_fire)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.is_boost && sts.boost_ok)
                begin
                    cmd.boost_init = 1'b1;
                    state_next = S_BREAD;
                end
                else if (!sts.read_wait)
                begin
                    cmd.exec = 1'b1;
                    state_next = S_DONE;
                end
                else
                    cmd.exec = 1'b1;
            end
            S_BREAD:
            begin
                if (sts.boost_done)
                begin
                    cmd.boost_end = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.boost_read = 1'b1;
                    state_next = S_BWRITE;
                end
            end
            S_BWRITE:
            begin
                cmd.boost_write = 1'b1;
                state_next = S_BREAD;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/mlfq_dp.sv -----
module mlfq_dp
    import mlfq_pkg::*;
#(
    parameter int NUM_LEVELS  = 3,
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  req_t                 req,
    input  logic [QUANT_W-1:0]   quant0,
    input  logic [QUANT_W-1:0]   quant1,
    input  logic [QUANT_W-1:0]   quant2,
    output sts_t                 sts,
    output rsp_t                 rsp
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int TW = $clog2(NUM_LEVELS * QUEUE_DEPTH + 1);
    localparam int SLOTS = 1 << PW;
    localparam int AW = LW + PW;

    logic [5:0] mem [NUM_LEVELS * SLOTS];
    logic [5:0] rd_data_reg;

    logic [PW-1:0] head_reg  [NUM_LEVELS];
    logic [PW-1:0] tail_reg  [NUM_LEVELS];
    logic [CW-1:0] count_reg [NUM_LEVELS];

    req_t            r_reg;
    logic [LW-1:0]   sel_lvl_reg;
    logic            sel_found_reg;
    logic [LW-1:0]   dem_lvl_reg;
    logic            lvl_ok_reg;
    logic            boost_ok_reg;
    logic            rd_pend_reg;
    logic [LW-1:0]   bsrc_reg;
    logic [PW-1:0]   bwr_reg;
    logic [CW-1:0]   bnum_reg;
    rsp_t            rsp_reg;

    logic [LW-1:0]   sel_lvl_c;
    logic            sel_found_c;
    logic [TW-1:0]   total_c;
    logic [LW-1:0]   lvl_c;
    logic            any_c;
    logic            bnext_empty;
    logic [LW-1:0]   bsrc_adv;
    logic            bscan_done;
    logic [QUANT_W-1:0] quant_c;
    rsp_t            rsp_c;

    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] l,
                                               input logic [PW-1:0] p);
        return {l, p};
    endfunction

    always_comb
    begin
        sel_found_c = 1'b0;
        sel_lvl_c = '0;
        total_c = '0;
        any_c = 1'b0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                sel_found_c = 1'b1;
                sel_lvl_c = LW'(l);
            end
        end
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            total_c = total_c + TW'(count_reg[l]);
            any_c = any_c | (count_reg[l] != '0);
        end
        lvl_c = LW'(r_reg.task_level);
        case (r_reg.task_level)
            2'd0:    quant_c = quant0;
            2'd1:    quant_c = quant1;
            default: quant_c = quant2;
        endcase
    end

    // boost: find next nonempty source level at or after bsrc_reg
    always_comb
    begin
        bnext_empty = 1'b1;
        bsrc_adv = bsrc_reg;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (LW'(l) >= bsrc_reg && count_reg[l] != '0)
            begin
                bnext_empty = 1'b0;
                bsrc_adv = LW'(l);
            end
        end
        bscan_done = bnext_empty;
    end

    assign sts.is_boost   = (r_reg.action == ACT_BOOST);
    assign sts.boost_ok   = boost_ok_reg;
    assign sts.boost_done = bscan_done;
    assign sts.read_wait  = rd_pend_reg;

    always_comb
    begin
        rsp = rsp_reg;
        rsp.any_ready = any_c;
    end

    // memory
    always_ff @(posedge clk)
    begin
        if (cmd.decode && r_reg.action == ACT_SELECT && sel_found_c)
            rd_data_reg <= mem[addr_of(sel_lvl_c, head_reg[sel_lvl_c])];
        else if (cmd.boost_read)
            rd_data_reg <= mem[addr_of(bsrc_adv, head_reg[bsrc_adv])];
        if (cmd.exec && !rd_pend_reg && lvl_ok_reg && !r_reg.task_terminated
            && r_reg.action == ACT_DEMOTE && count_reg[dem_lvl_reg] != CW'(QUEUE_DEPTH))
            mem[addr_of(dem_lvl_reg, tail_reg[dem_lvl_reg])] <= r_reg.task_id;
        else if (cmd.exec && !rd_pend_reg && lvl_ok_reg && r_reg.action == ACT_ADD
            && count_reg[lvl_c] != CW'(QUEUE_DEPTH))
            mem[addr_of(lvl_c, tail_reg[lvl_c])] <= r_reg.task_id;
        else if (cmd.boost_write)
            mem[addr_of('0, bwr_reg)] <= rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
            r_reg <= req;
        if (cmd.decode)
        begin
            sel_lvl_reg   <= sel_lvl_c;
            sel_found_reg <= sel_found_c;
            lvl_ok_reg    <= (32'(r_reg.task_level) < NUM_LEVELS);
            dem_lvl_reg   <= (32'(r_reg.task_level) + 1 < NUM_LEVELS) ?
                             LW'(r_reg.task_level + 2'd1) : LW'(NUM_LEVELS - 1);
            boost_ok_reg  <= (total_c <= TW'(QUEUE_DEPTH));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
            bsrc_reg <= '0;
            bwr_reg <= '0;
            bnum_reg <= '0;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                count_reg[l] <= '0;
            end
        end
        else
        begin
            if (cmd.decode)
                rd_pend_reg <= (r_reg.action == ACT_SELECT);
            else if (cmd.exec)
                rd_pend_reg <= 1'b0;
            if (cmd.exec && !rd_pend_reg)
            begin
                unique case (r_reg.action)
                    ACT_ADD:
                        if (lvl_ok_reg && count_reg[lvl_c] != CW'(QUEUE_DEPTH))
                        begin
                            tail_reg[lvl_c] <= tail_reg[lvl_c] + 1'b1;
                            count_reg[lvl_c] <= count_reg[lvl_c] + 1'b1;
                        end
                    ACT_SELECT:
                        if (sel_found_reg)
                        begin
                            head_reg[sel_lvl_reg] <= head_reg[sel_lvl_reg] + 1'b1;
                            count_reg[sel_lvl_reg] <= count_reg[sel_lvl_reg] - 1'b1;
                        end
                    ACT_DEMOTE:
                        if (lvl_ok_reg && !r_reg.task_terminated
                            && count_reg[dem_lvl_reg] != CW'(QUEUE_DEPTH))
                        begin
                            tail_reg[dem_lvl_reg] <= tail_reg[dem_lvl_reg] + 1'b1;
                            count_reg[dem_lvl_reg] <= count_reg[dem_lvl_reg] + 1'b1;
                        end
                    default: ;
                endcase
            end
            // level 0 entries are copied in place, the rest follow them
            if (cmd.boost_init)
            begin
                bsrc_reg <= '0;
                bwr_reg <= head_reg[0];
                bnum_reg <= '0;
            end
            if (cmd.boost_read)
            begin
                bsrc_reg <= bsrc_adv;
                head_reg[bsrc_adv] <= head_reg[bsrc_adv] + 1'b1;
                count_reg[bsrc_adv] <= count_reg[bsrc_adv] - 1'b1;
            end
            if (cmd.boost_write)
            begin
                bwr_reg <= bwr_reg + 1'b1;
                bnum_reg <= bnum_reg + 1'b1;
            end
            if (cmd.boost_end)
            begin
                for (int l = 1; l < NUM_LEVELS; l++)
                begin
                    head_reg[l] <= '0;
                    tail_reg[l] <= '0;
                    count_reg[l] <= '0;
                end
                head_reg[0] <= bwr_reg - PW'(bnum_reg);
                tail_reg[0] <= bwr_reg;
                count_reg[0] <= bnum_reg;
            end
        end
    end

    always_comb
    begin
        rsp_c = '0;
        unique case (r_reg.action)
            ACT_ADD:
                if (!lvl_ok_reg)
                    rsp_c.status = ST_BAD_LVL;
                else if (count_reg[lvl_c] == CW'(QUEUE_DEPTH))
                    rsp_c.status = ST_FULL;
            ACT_SELECT:
                if (sel_found_reg)
                begin
                    rsp_c.chosen_id = rd_data_reg;
                    rsp_c.chosen_valid = 1'b1;
                end
            ACT_CHECK:
                if (!lvl_ok_reg)
                    rsp_c.status = ST_BAD_LVL;
                else
                    rsp_c.quantum_exhausted = (r_reg.quantum_used >= quant_c);
            ACT_DEMOTE:
                if (!r_reg.task_terminated)
                begin
                    if (!lvl_ok_reg)
                        rsp_c.status = ST_BAD_LVL;
                    else if (count_reg[dem_lvl_reg] == CW'(QUEUE_DEPTH))
                        rsp_c.status = ST_FULL;
                    else
                        rsp_c.new_level = LEVEL_W'(dem_lvl_reg);
                end
            ACT_BOOST:
                rsp_c.status = ST_FULL;
            default: ;
        endcase
    end

    // result register, cleared at decode and built when the controller leaves exec for done
    always_ff @(posedge clk)
    begin
        if (cmd.decode)
            rsp_reg <= '0;
        else if (cmd.exec && !rd_pend_reg)
            rsp_reg <= rsp_c;
    end

endmodule

// ----- hw/rtl/mlfq_ready_queue_scheduler.sv -----
// channel   valid      ready      payload
// in        in_valid   in_ready   in_data   (req_t)
// out       out_valid  out_ready  out_data  (rsp_t)
// cfg       cfg_valid  cfg_ready  cfg_index, cfg_data
// add, check, demote and refused boost pass through decode, exec and done; select waits in exec for its read
// in_ready rises again in the cycle after the result is loaded
// boost moves each queued id with a read state and then a write state
// reset empties all queues and loads the default quanta; no clearing pass
// a held result stalls the controller until out_ready
module mlfq_ready_queue_scheduler
    import mlfq_pkg::*;
#(
    parameter int NUM_LEVELS  = 3,
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  req_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsp_t                 out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [QUANT_W-1:0]   cfg_data
);

    cmd_t cmd;
    sts_t sts;
    rsp_t rsp;
    logic in_fire;
    logic out_valid_reg;
    rsp_t out_data_reg;
    logic [QUANT_W-1:0] q0_reg, q1_reg, q2_reg;

    assign in_fire = in_valid & in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q0_reg <= Q0_RESET;
            q1_reg <= Q1_RESET;
            q2_reg <= Q2_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_Q0:  q0_reg <= cfg_data;
                CFG_Q1:  q1_reg <= cfg_data;
                CFG_Q2:  q2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    mlfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_valid_reg & ~out_ready),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    mlfq_dp #(
        .NUM_LEVELS  (NUM_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (in_data),
        .quant0 (q0_reg),
        .quant1 (q1_reg),
        .quant2 (q2_reg),
        .sts    (sts),
        .rsp    (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            out_data_reg <= rsp;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decode |-> !in_ready) else $error("accept while busy");
    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid) else $error("result lost");
    a_boost_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.boost_read && cmd.boost_write)) else $error("boost port clash");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import mlfq_pkg::*;

    localparam int LEVELS = 3;
    localparam int DEPTH = 64;
    localparam int ITEM_TARGET = 1250;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam logic [ACTION_W-1:0] ACT_RSVD_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD_HI = 3'd7;
    localparam logic [LEVEL_W-1:0] LVL_BAD = 2'd3;

    typedef enum int {MIX_OPS, FILL_QUEUE, DRAIN_QUEUE} phase_kind_e;

    typedef struct {
        req_t r;
        bit   fixed;
        rsp_t e;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [QUANT_W-1:0] cfg_data;

    logic [5:0] ready_q [LEVELS][$];
    logic [QUANT_W-1:0] slice_max [LEVELS];
    rsp_t pending_rsp [$];
    int mismatches = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int burst_left = 0;
    bit no_gaps = 0;
    bit holdoff_req = 0;
    int holdoff_left = 0;
    int ready_mode = 0;

    mlfq_ready_queue_scheduler dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic req_t make_req(logic [ACTION_W-1:0] act, logic [5:0] id,
                                      logic [LEVEL_W-1:0] lvl, logic [QUANT_W-1:0] used,
                                      logic term);
        req_t r;
        r.action = act;
        r.task_id = id;
        r.task_level = lvl;
        r.quantum_used = used;
        r.task_terminated = term;
        return r;
    endfunction

    function automatic rsp_t make_rsp(logic [5:0] id, logic vld, logic exh,
                                      logic [LEVEL_W-1:0] lvl, logic rdy,
                                      logic [STATUS_W-1:0] st);
        rsp_t e;
        e.chosen_id = id;
        e.chosen_valid = vld;
        e.quantum_exhausted = exh;
        e.new_level = lvl;
        e.any_ready = rdy;
        e.status = st;
        return e;
    endfunction

    // scheduler behavior, updates the shadow queues
    function automatic rsp_t schedule_step(req_t r);
        rsp_t e;
        int tgt;
        int total;
        logic [5:0] merged [$];
        e = make_rsp(6'd0, 1'b0, 1'b0, 2'd0, 1'b0, ST_OK);
        case (r.action)
            ACT_ADD:
                if (r.task_level >= LEVELS)
                    e.status = ST_BAD_LVL;
                else if (ready_q[r.task_level].size() >= DEPTH)
                    e.status = ST_FULL;
                else
                    ready_q[r.task_level] = {ready_q[r.task_level], r.task_id};
            ACT_SELECT:
                for (int l = 0; l < LEVELS; l++)
                begin
                    if (ready_q[l].size() != 0)
                    begin
                        e.chosen_id = ready_q[l].pop_front();
                        e.chosen_valid = 1'b1;
                        break;
                    end
                end
            ACT_CHECK:
                if (r.task_level >= LEVELS)
                    e.status = ST_BAD_LVL;
                else
                    e.quantum_exhausted = (r.quantum_used >= slice_max[r.task_level]);
            ACT_DEMOTE:
                if (!r.task_terminated)
                begin
                    if (r.task_level >= LEVELS)
                        e.status = ST_BAD_LVL;
                    else
                    begin
                        tgt = (r.task_level + 1 < LEVELS) ? r.task_level + 1 : LEVELS - 1;
                        if (ready_q[tgt].size() >= DEPTH)
                            e.status = ST_FULL;
                        else
                        begin
                            ready_q[tgt] = {ready_q[tgt], r.task_id};
                            e.new_level = tgt[LEVEL_W-1:0];
                        end
                    end
                end
            ACT_BOOST:
            begin
                total = 0;
                for (int l = 0; l < LEVELS; l++)
                    total += ready_q[l].size();
                if (total > DEPTH)
                    e.status = ST_FULL;
                else
                begin
                    for (int l = 0; l < LEVELS; l++)
                    begin
                        merged = {merged, ready_q[l]};
                        ready_q[l].delete();
                    end
                    ready_q[0] = merged;
                end
            end
            default: ;
        endcase
        for (int l = 0; l < LEVELS; l++)
            if (ready_q[l].size() != 0)
                e.any_ready = 1'b1;
        return e;
    endfunction

    function automatic req_t random_req(phase_kind_e kind, int fav_lvl);
        int pick;
        logic [ACTION_W-1:0] act;
        logic [LEVEL_W-1:0] lvl;
        logic [QUANT_W-1:0] used;
        pick = $urandom_range(0, 99);
        case (kind)
            FILL_QUEUE:
                act = (pick < 60) ? ACT_ADD : (pick < 80) ? ACT_DEMOTE :
                      (pick < 88) ? ACT_CHECK : (pick < 94) ? ACT_BOOST :
                      (pick < 98) ? ACT_SELECT : ACT_RSVD_LO;
            DRAIN_QUEUE:
                act = (pick < 60) ? ACT_SELECT : (pick < 75) ? ACT_ADD :
                      (pick < 85) ? ACT_CHECK : (pick < 93) ? ACT_DEMOTE :
                      (pick < 97) ? ACT_BOOST : ACT_RSVD_HI;
            default:
                act = (pick < 25) ? ACT_ADD : (pick < 50) ? ACT_SELECT :
                      (pick < 70) ? ACT_CHECK : (pick < 85) ? ACT_DEMOTE :
                      (pick < 95) ? ACT_BOOST :
                      ACTION_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 8)
            lvl = LVL_BAD;
        else if (kind == FILL_QUEUE && pick < 85)
            lvl = fav_lvl[LEVEL_W-1:0];
        else
            lvl = LEVEL_W'($urandom_range(0, LEVELS - 1));
        if ($urandom_range(0, 1) && lvl < LEVELS)
            used = QUANT_W'(slice_max[lvl] - 1 + $urandom_range(0, 2));
        else
            used = QUANT_W'($urandom_range(0, 16'hffff));
        return make_req(act, 6'($urandom_range(0, 63)), lvl, used,
                        $urandom_range(0, 3) == 0);
    endfunction

    task automatic send_req(req_t r, bit fixed, rsp_t typed);
        int gap;
        rsp_t e;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= r;
        do @(posedge clk); while (!in_ready);
        e = schedule_step(r);
        if (fixed)
            e = typed;
        pending_rsp = {pending_rsp, e};
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_quantum(logic [CFG_IDX_W-1:0] idx, logic [QUANT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        slice_max[idx] = val;
    endtask

    // result checking and receiver stalls
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %p", out_data);
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (out_data.chosen_id !== e.chosen_id
                    || out_data.chosen_valid !== e.chosen_valid
                    || out_data.quantum_exhausted !== e.quantum_exhausted
                    || out_data.new_level !== e.new_level
                    || out_data.any_ready !== e.any_ready
                    || out_data.status !== e.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", e, out_data);
                end
            end
        end
        if (cycle_count % 64 == 0)
            ready_mode = $urandom_range(0, 3);
        if (holdoff_req)
        begin
            holdoff_req = 0;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left != 0)
        begin
            holdoff_left--;
            out_ready <= 1'b0;
        end
        else
            case (ready_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                2: out_ready <= ($urandom_range(0, 7) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("mlfq_ready_queue_scheduler test failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        int phase;
        int fav_lvl;
        int n_items;
        phase_kind_e kind;
        logic [QUANT_W-1:0] qval;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_Q0;
        cfg_data = '0;
        slice_max[0] = Q0_RESET;
        slice_max[1] = Q1_RESET;
        slice_max[2] = Q2_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queues first, then a small populated set
        row.fixed = 1;
        row.e = make_rsp(6'd0, 1'b0, 1'b0, 2'd0, 1'b0, ST_OK);
        row.r = make_req(ACT_SELECT, 6'd0, 2'd0, 16'd0, 1'b0); rows = {rows, row};
        row.r = make_req(ACT_BOOST, 6'd63, 2'd0, 16'd0, 1'b0); rows = {rows, row};
        row.r = make_req(ACT_DEMOTE, 6'd5, LVL_BAD, 16'd0, 1'b1); rows = {rows, row};
        row.r = make_req(ACT_RSVD_LO, 6'd63, 2'd1, 16'hffff, 1'b1); rows = {rows, row};
        row.r = make_req(ACT_RSVD_HI, 6'd0, 2'd0, 16'd0, 1'b0); rows = {rows, row};
        row.r = make_req(ACT_CHECK, 6'd1, 2'd0, 16'd7, 1'b0); rows = {rows, row};
        row.e.status = ST_BAD_LVL;
        row.r = make_req(ACT_ADD, 6'd7, LVL_BAD, 16'd0, 1'b0); rows = {rows, row};
        row.r = make_req(ACT_CHECK, 6'd7, LVL_BAD, 16'hffff, 1'b0); rows = {rows, row};
        row.r = make_req(ACT_DEMOTE, 6'd7, LVL_BAD, 16'd0, 1'b0); rows = {rows, row};
        row.e = make_rsp(6'd0, 1'b0, 1'b1, 2'd0, 1'b0, ST_OK);
        row.r = make_req(ACT_CHECK, 6'd2, 2'd0, 16'd8, 1'b0); rows = {rows, row};
        row.r = make_req(ACT_CHECK, 6'd2, 2'd2, 16'hffff, 1'b0); rows = {rows, row};
        row.fixed = 0;
        row.r = make_req(ACT_ADD, 6'd63, 2'd0, 16'd0, 1'b0); rows = {rows, row};
        row.r = make_req(ACT_ADD, 6'd0, 2'd1, 16'hffff, 1'b1); rows = {rows, row};
        row.r = make_req(ACT_ADD, 6'd42, 2'd2, 16'd0, 1'b0); rows = {rows, row};
        row.r = make_req(ACT_DEMOTE, 6'd5, 2'd0, 16'd0, 1'b0); rows = {rows, row};
        row.r = make_req(ACT_DEMOTE, 6'd9, 2'd2, 16'd0, 1'b0); rows = {rows, row};
        row.r = make_req(ACT_DEMOTE, 6'd11, 2'd1, 16'd0, 1'b1); rows = {rows, row};
        row.r = make_req(ACT_CHECK, 6'd3, 2'd1, 16'd16, 1'b0); rows = {rows, row};
        row.r = make_req(ACT_CHECK, 6'd3, 2'd1, 16'd15, 1'b0); rows = {rows, row};
        row.r = make_req(ACT_BOOST, 6'd0, 2'd0, 16'd0, 1'b0); rows = {rows, row};
        for (int i = 0; i < 6; i++)
        begin
            row.r = make_req(ACT_SELECT, 6'd0, 2'd0, 16'd0, 1'b0);
            rows = {rows, row};
        end
        foreach (rows[i])
            send_req(rows[i].r, rows[i].fixed, rows[i].e);
        wait_idle();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case ((phase / 3) % 4)
                0: qval = 16'd1;
                1: qval = 16'hffff;
                2: qval = QUANT_W'($urandom_range(1, 16'hffff));
                default: qval = QUANT_W'($urandom_range(1, 64));
            endcase
            write_quantum(CFG_IDX_W'(phase % 3), qval);
            kind = phase_kind_e'(phase % 3);
            fav_lvl = $urandom_range(0, LEVELS - 1);
            no_gaps = ($urandom_range(0, 3) == 0);
            n_items = (kind == FILL_QUEUE) ? $urandom_range(120, 180) : $urandom_range(30, 90);
            for (int i = 0; i < n_items; i++)
            begin
                if (phase == 1 && i == 10)
                    holdoff_req = 1;
                send_req(random_req(kind, fav_lvl), 1'b0, row.e);
            end
            wait_idle();
            phase++;
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("mlfq_ready_queue_scheduler test passed");
        else
            $display("mlfq_ready_queue_scheduler test failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/mlfq_pkg.sv
hw/rtl/mlfq_ctrl.sv
hw/rtl/mlfq_dp.sv
hw/rtl/mlfq_ready_queue_scheduler.sv
sim/testbench.sv
